// ----- design/pcm_constellation_power_index_assert.svh -----
// ----------------------------------------------------------------------------
// pcm constellation power index assertion macros
// shared concurrent assertion forms on clk_i with reset disable
// ----------------------------------------------------------------------------
`ifndef PCM_CONSTELLATION_POWER_INDEX_ASSERT_SVH
`define PCM_CONSTELLATION_POWER_INDEX_ASSERT_SVH

// same-cycle implication
`define PCMCPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCMCPI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pcmcpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmcpi_pkg
// types, constants and functions of the pcm constellation power index block
// ----------------------------------------------------------------------------
package pcmcpi_pkg;

  localparam int POSITIONS    = 6;
  localparam int MAX_POINTS   = 128;
  localparam int LADDER_STEPS = 35;
  localparam int K_LIMIT      = 42;
  localparam int QW           = 42;
  localparam int NW           = QW + 1;
  localparam int CW           = QW + 2;
  localparam int ACCW         = 80;
  localparam int MW           = 30;
  localparam int IW           = 6;
  localparam int HALF         = 22;

  localparam logic [5:0]    K_RESET    = 6'd42;
  localparam logic [7:0]    SIZE_RESET = 8'd128;
  localparam logic [7:0]    MEAN_DIV   = 8'd6;
  localparam logic [MW-1:0] MEAN_MAX   = {MW{1'b1}};
  localparam logic [QW-1:0] TRUNC_MASK = {QW{1'b1}} << 32;
  localparam logic [IW-1:0] IDX_TOP    = IW'(LADDER_STEPS - 1);

  // configuration register indexes
  localparam logic [2:0] RegCwBits = 3'd0;
  localparam logic [2:0] RegSize0  = 3'd1;
  localparam logic [2:0] RegSize5  = 3'd6;

  localparam logic [31:0] LADDER [LADDER_STEPS] = '{
    32'd228735376, 32'd203804176, 32'd181710400, 32'd161900176, 32'd144288144,
    32'd128595600, 32'd114661264, 32'd102171664, 32'd91087936,  32'd81144064,
    32'd72318016,  32'd64448784,  32'd57456400,  32'd51208336,  32'd45643536,
    32'd40704400,  32'd36240400,  32'd32307856,  32'd28815424,  32'd25684624,
    32'd22886656,  32'd20394256,  32'd18181696,  32'd16192576,  32'd14440000,
    32'd12873744,  32'd11478544,  32'd10214416,  32'd9120400,   32'd8133904,
    32'd7246864,   32'd6451600,   32'd5740816,   32'd5112121,   32'd4549689
  };

  typedef struct packed {
    logic       mode;
    logic [2:0] position;
    logic [6:0] point_number;
    logic [7:0] plain_byte;
    logic [7:0] codec_byte;
    logic       use_codec;
    logic       mu_law;
  } in_word_t;

  typedef struct packed {
    logic [MW-1:0] mean_power;
    logic [IW-1:0] ladder_index;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic start;
    logic div_rdx;
    logic rdx_save;
    logic mul_qn;
    logic save_qn;
    logic mul_qi;
    logic save_qi;
    logic mem_rd;
    logic sq;
    logic mul_lo;
    logic mul_hi;
    logic acc_add;
    logic div_mean;
    logic mean_save;
    logic neg_set;
    logic lad_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic pos_last;
    logic j_last;
    logic acc_neg;
    logic lad_stop;
    logic out_free;
  } sts_t;

  // g.711 expanded magnitude
  function automatic logic [14:0] level_mag(input logic [7:0] code, input logic mu);
    logic [6:0]  b;
    logic [2:0]  seg;
    logic [15:0] t;
    b   = code[6:0];
    seg = b[6:4];
    if (mu) begin
      t = 16'({b[3:0], 3'b000}) + 16'h84;
      t = t << seg;
      level_mag = 15'(t - 16'h84);
    end else begin
      t = 16'({b[3:0], 4'b0000});
      if (seg == 3'd0) begin
        t = t + 16'd8;
      end else begin
        t = (t + 16'h108) << (seg - 3'd1);
      end
      level_mag = 15'(t);
    end
  endfunction

  // ladder limit times six
  function automatic logic [30:0] ladder6(input logic [IW-1:0] i);
    logic [31:0] v;
    v = '0;
    if (i <= IDX_TOP) begin
      v = LADDER[i] * 32'd6;
    end
    ladder6 = 31'(v);
  endfunction

endpackage

// ----- design/pcmcpi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmcpi_div
// restoring divider, one quotient bit per cycle, narrow divisor
// ----------------------------------------------------------------------------
module pcmcpi_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [pcmcpi_pkg::QW-1:0] dividend_i,
  input  logic [7:0]              divisor_i,
  output logic                    done_o,
  output logic [pcmcpi_pkg::QW-1:0] quot_o,
  output logic [7:0]              rem_o
);
  import pcmcpi_pkg::*;

  localparam int CNTW = $clog2(QW + 1);

  logic [QW-1:0]   quot_q;
  logic [7:0]      rem_q;
  logic [7:0]      dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [8:0]      trial;
  logic            ge;

  assign trial = {rem_q, quot_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign done_o = !busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/pcmcpi_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmcpi_dp
// point tables, radix split, count products, power sum, mean and ladder
// ----------------------------------------------------------------------------
module pcmcpi_dp #(
  parameter int MaxPoints = pcmcpi_pkg::MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcmcpi_pkg::cmd_t      cmd_i,
  output pcmcpi_pkg::sts_t      sts_o,
  input  pcmcpi_pkg::in_word_t  in_word_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pcmcpi_pkg::out_word_t out_word_o
);
  import pcmcpi_pkg::*;

  localparam int Depth = POSITIONS * MaxPoints;
  localparam int AW    = $clog2(Depth);
  localparam int JW    = $clog2(MaxPoints);

  // configuration
  logic [5:0] k_q;
  logic [7:0] size_q [POSITIONS];
  logic [7:0] s_eff  [POSITIONS];
  logic [5:0] kk;
  logic [NW-1:0] n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
      for (int i = 0; i < POSITIONS; i++) begin
        size_q[i] <= SIZE_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegCwBits) begin
        k_q <= cfg_wdata_i[5:0];
      end else if (cfg_idx_i inside {[RegSize0:RegSize5]}) begin
        size_q[3'(cfg_idx_i - RegSize0)] <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < POSITIONS; i++) begin
      if (size_q[i] == 8'd0) begin
        s_eff[i] = 8'd1;
      end else if ({1'b0, size_q[i]} > 9'(MaxPoints)) begin
        s_eff[i] = 8'(MaxPoints);
      end else begin
        s_eff[i] = size_q[i];
      end
    end
  end

  assign kk = (k_q > 6'(K_LIMIT)) ? 6'(K_LIMIT) : k_q;
  assign n  = NW'(1) << kk;

  // point memory, plain in the upper byte
  logic [15:0]   mem [Depth];
  logic [15:0]   rd_q;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_ok;

  logic [2:0]    pos_q;
  logic [JW-1:0] j_q;

  assign wr_addr = AW'(in_word_i.position) * AW'(MaxPoints) + AW'(in_word_i.point_number);
  assign rd_addr = AW'(pos_q) * AW'(MaxPoints) + AW'(j_q);
  assign wr_ok   = (in_word_i.position < 3'(POSITIONS)) &&
                   (9'(in_word_i.point_number) < 9'(MaxPoints));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem[wr_addr] <= {in_word_i.plain_byte, in_word_i.codec_byte};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // radix split
  logic [QW-1:0] q_q [POSITIONS + 1];
  logic [QW-1:0] d_q [POSITIONS];
  logic [QW-1:0] p_q [POSITIONS];
  logic          use_codec_q;
  logic          mu_q;
  logic          pos_last;
  logic          j_last;

  logic          div_start;
  logic [QW-1:0] div_dividend;
  logic [7:0]    div_divisor;
  logic          div_done;
  logic [QW-1:0] div_quot;
  logic [7:0]    div_rem;

  logic [ACCW-1:0] acc_q;
  logic [ACCW-1:0] shifted;
  logic            sat;

  assign pos_last = pos_q == 3'(POSITIONS - 1);
  assign j_last   = (9'(j_q) + 9'd1) == {1'b0, s_eff[pos_q]};
  assign shifted  = acc_q >> kk;
  assign sat      = |shifted[ACCW-1:QW];

  assign div_start   = cmd_i.div_rdx | cmd_i.div_mean;
  assign div_divisor = cmd_i.div_mean ? MEAN_DIV : s_eff[pos_q];
  always_comb begin
    if (cmd_i.div_mean) begin
      div_dividend = shifted[QW-1:0];
    end else if (pos_last) begin
      div_dividend = q_q[pos_q] & TRUNC_MASK;
    end else begin
      div_dividend = q_q[pos_q];
    end
  end

  pcmcpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // shift-add multiplier for the count products
  logic [CW-1:0] mula_q;
  logic [QW-1:0] mulb_q;
  logic [CW-1:0] mulr_q;
  logic [CW-1:0] cgt_q;
  logic [CW-1:0] pqi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_qn || cmd_i.mul_qi) begin
      mula_q <= CW'(p_q[pos_q]);
      mulb_q <= cmd_i.mul_qn ? q_q[3'(pos_q + 3'd1)] : q_q[pos_q];
      mulr_q <= '0;
    end else if (mulb_q != '0) begin
      if (mulb_q[0]) begin
        mulr_q <= mulr_q + mula_q;
      end
      mula_q <= mula_q << 1;
      mulb_q <= mulb_q >> 1;
    end
    if (cmd_i.save_qn) begin
      cgt_q <= mulr_q;
    end
    if (cmd_i.save_qi) begin
      pqi_q <= mulr_q;
    end
  end

  // per point count, square and product
  logic [14:0]      mag;
  logic [MW-1:0]    sq_q;
  logic [CW-1:0]    cmag_q;
  logic             cneg_q;
  logic [CW:0]      ceq;
  logic [CW-1:0]    cmag;
  logic             cneg;
  logic [HALF-1:0]  mop;
  logic [MW+HALF-1:0] prod;
  logic [MW+HALF-1:0] plo_q;
  logic [MW+HALF-1:0] phi_q;
  logic [ACCW-1:0]  term;

  assign mag = level_mag(use_codec_q ? rd_q[7:0] : rd_q[15:8], mu_q);
  assign ceq = (CW+1)'(n) + (CW+1)'(cgt_q) - (CW+1)'(pqi_q);

  always_comb begin
    cneg = 1'b0;
    if (d_q[pos_q] > QW'(j_q)) begin
      cmag = cgt_q + CW'(p_q[pos_q]);
    end else if (d_q[pos_q] == QW'(j_q)) begin
      cneg = ceq[CW];
      cmag = cneg ? CW'(-ceq) : CW'(ceq);
    end else begin
      cmag = cgt_q;
    end
  end

  assign mop  = cmd_i.mul_hi ? cmag_q[CW-1:HALF] : cmag_q[HALF-1:0];
  assign prod = {{HALF{1'b0}}, sq_q} * {{MW{1'b0}}, mop};
  assign term = (ACCW'(phi_q) << HALF) + ACCW'(plo_q);

  // mean and ladder
  logic [MW-1:0]   mean_q;
  logic [IW-1:0]   idx_q;
  logic [ACCW-1:0] lim;
  logic            below;

  assign lim   = ACCW'(ladder6(idx_q)) << kk;
  assign below = lim < acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q[0]      <= QW'(n - NW'(1));
      p_q[0]      <= QW'(1);
      acc_q       <= '0;
      use_codec_q <= in_word_i.use_codec;
      mu_q        <= in_word_i.mu_law;
    end
    if (cmd_i.rdx_save) begin
      q_q[3'(pos_q + 3'd1)] <= div_quot;
      if (pos_last) begin
        d_q[pos_q] <= q_q[pos_q] & ~TRUNC_MASK;
      end else begin
        d_q[pos_q]            <= QW'(div_rem);
        p_q[3'(pos_q + 3'd1)] <= QW'(p_q[pos_q] * QW'(s_eff[pos_q]));
      end
    end
    if (cmd_i.sq) begin
      sq_q   <= MW'({15'd0, mag} * {15'd0, mag});
      cmag_q <= cmag;
      cneg_q <= cneg;
    end
    if (cmd_i.mul_lo) begin
      plo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= prod;
    end
    if (cmd_i.acc_add) begin
      acc_q <= cneg_q ? acc_q - term : acc_q + term;
    end
    if (cmd_i.neg_set) begin
      mean_q <= '0;
      idx_q  <= IDX_TOP;
    end
    if (cmd_i.mean_save) begin
      mean_q <= (sat || (div_quot > QW'(MEAN_MAX))) ? MEAN_MAX : div_quot[MW-1:0];
      idx_q  <= IDX_TOP;
    end
    if (cmd_i.lad_dec) begin
      idx_q <= idx_q - IW'(1);
    end
  end

  // step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      j_q   <= '0;
    end else if (cmd_i.start) begin
      pos_q <= '0;
      j_q   <= '0;
    end else if (cmd_i.rdx_save) begin
      pos_q <= pos_last ? 3'd0 : 3'(pos_q + 3'd1);
    end else if (cmd_i.acc_add) begin
      if (j_last) begin
        j_q <= '0;
        if (!pos_last) begin
          pos_q <= 3'(pos_q + 3'd1);
        end
      end else begin
        j_q <= JW'(j_q + JW'(1));
      end
    end
  end

  // output register
  logic      out_valid_q;
  out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q <= '{mean_power: mean_q, ladder_index: idx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign sts_o = '{
    div_done: div_done,
    mul_done: mulb_q == '0,
    pos_last: pos_last,
    j_last:   j_last,
    acc_neg:  acc_q[ACCW-1],
    lad_stop: (idx_q == '0) || !below,
    out_free: !out_valid_q || !out_stall_i
  };

endmodule

// ----- design/pcmcpi_ctrl.sv -----
`timescale 1ns / 1ps
`include "pcm_constellation_power_index_assert.svh"
// ----------------------------------------------------------------------------
// pcmcpi_ctrl
// sequencer for table loads and the power computation
// ----------------------------------------------------------------------------
module pcmcpi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             mode_i,
  output logic             in_stall_o,
  output pcmcpi_pkg::cmd_t cmd_o,
  input  pcmcpi_pkg::sts_t sts_i
);
  import pcmcpi_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDX_GO  = 4'd1;
  localparam logic [3:0] S_RDX_WT  = 4'd2;
  localparam logic [3:0] S_POS_GO  = 4'd3;
  localparam logic [3:0] S_POS_WT1 = 4'd4;
  localparam logic [3:0] S_POS_GO2 = 4'd5;
  localparam logic [3:0] S_POS_WT2 = 4'd6;
  localparam logic [3:0] S_PT_RD   = 4'd7;
  localparam logic [3:0] S_PT_SQ   = 4'd8;
  localparam logic [3:0] S_PT_ML   = 4'd9;
  localparam logic [3:0] S_PT_MH   = 4'd10;
  localparam logic [3:0] S_PT_ACC  = 4'd11;
  localparam logic [3:0] S_MEAN_GO = 4'd12;
  localparam logic [3:0] S_MEAN_WT = 4'd13;
  localparam logic [3:0] S_LAD     = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.start = 1'b1;
            state_d     = S_RDX_GO;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_RDX_GO: begin
        cmd_o.div_rdx = 1'b1;
        state_d       = S_RDX_WT;
      end
      S_RDX_WT: begin
        if (sts_i.div_done) begin
          cmd_o.rdx_save = 1'b1;
          state_d        = sts_i.pos_last ? S_POS_GO : S_RDX_GO;
        end
      end
      S_POS_GO: begin
        cmd_o.mul_qn = 1'b1;
        state_d      = S_POS_WT1;
      end
      S_POS_WT1: begin
        if (sts_i.mul_done) begin
          cmd_o.save_qn = 1'b1;
          state_d       = S_POS_GO2;
        end
      end
      S_POS_GO2: begin
        cmd_o.mul_qi = 1'b1;
        state_d      = S_POS_WT2;
      end
      S_POS_WT2: begin
        if (sts_i.mul_done) begin
          cmd_o.save_qi = 1'b1;
          state_d       = S_PT_RD;
        end
      end
      S_PT_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_PT_SQ;
      end
      S_PT_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_PT_ML;
      end
      S_PT_ML: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_PT_MH;
      end
      S_PT_MH: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_PT_ACC;
      end
      S_PT_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (sts_i.j_last) begin
          state_d = sts_i.pos_last ? S_MEAN_GO : S_POS_GO;
        end else begin
          state_d = S_PT_RD;
        end
      end
      S_MEAN_GO: begin
        if (sts_i.acc_neg) begin
          cmd_o.neg_set = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_mean = 1'b1;
          state_d        = S_MEAN_WT;
        end
      end
      S_MEAN_WT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_save = 1'b1;
          state_d         = S_LAD;
        end
      end
      S_LAD: begin
        if (sts_i.lad_stop) begin
          state_d = S_DONE;
        end else begin
          cmd_o.lad_dec = 1'b1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  `PCMCPI_ASSERT_IMP(a_acc_order, state_q == S_PT_ACC, $past(state_q) == S_PT_MH, "accumulate out of order")
  `PCMCPI_ASSERT_NXT(a_lad_exit, state_q == S_LAD, state_q == S_LAD || state_q == S_DONE, "ladder exit wrong")
  `PCMCPI_ASSERT_NXT(a_mean_to_lad, state_q == S_MEAN_WT && sts_i.div_done, state_q == S_LAD, "mean not followed by ladder")

endmodule

// ----- design/pcm_constellation_power_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_constellation_power_index
// average power and ladder index of a pcm constellation frame
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one point of both tables and is taken every cycle
// while the block is idle. A compute word (mode 1) holds the input stalled while
// the block runs six serial divisions, two shift-add count products per
// position, a read, square, low product, high product and accumulate step per
// constellation point through the single point memory port and product
// multiplier, then, unless the power sum is negative, one more division and a
// ladder search. The result waits in an output register, so loads go on while
// it is stalled.
module pcm_constellation_power_index #(
  parameter int MaxPoints = pcmcpi_pkg::MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcmcpi_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pcmcpi_pkg::out_word_t out_word_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i
);
  import pcmcpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcmcpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_word_i.mode),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pcmcpi_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- tb/sv/pcm_constellation_power_index_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm constellation power index checker
// tracks table loads and register writes, predicts the mean power and ladder
// index of every accepted compute word and compares each output word in order
// ----------------------------------------------------------------------------
module pcm_constellation_power_index_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  pcmcpi_pkg::in_word_t  in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  pcmcpi_pkg::out_word_t out_word_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    results_owed_o
);
  import pcmcpi_pkg::*;

  logic [7:0] plain_tab [POSITIONS][MAX_POINTS];
  logic [7:0] codec_tab [POSITIONS][MAX_POINTS];
  logic [5:0] cw_bits;
  logic [7:0] pos_size [POSITIONS];
  out_word_t  power_due [$];

  function automatic logic [31:0] linear_level(input logic [7:0] code, input logic mu);
    logic [2:0]  seg;
    logic [31:0] t;
    seg = code[6:4];
    if (mu) begin
      t = (32'({code[3:0], 3'b000}) + 32'd132) << seg;
      return t - 32'd132;
    end
    t = 32'({code[3:0], 4'b0000});
    if (seg == 3'd0) begin
      return t + 32'd8;
    end
    return (t + 32'd264) << (seg - 3'd1);
  endfunction

  function automatic out_word_t frame_power(input logic use_codec, input logic mu);
    int unsigned k;
    int          idx;
    logic [63:0] n, taken, cnt, msq, lvl;
    logic [63:0] s [POSITIONS];
    logic [63:0] d [POSITIONS];
    logic [63:0] p [POSITIONS];
    logic [63:0] q [POSITIONS+1];
    logic [127:0] sum, term, shifted, limit;
    logic [7:0]  code;
    logic        neg;
    out_word_t   r;
    for (int i = 0; i < POSITIONS; i++) begin
      s[i] = (pos_size[i] == 8'd0) ? 64'd1 :
             (pos_size[i] > MAX_POINTS) ? 64'(MAX_POINTS) : 64'(pos_size[i]);
    end
    k = (cw_bits > K_LIMIT) ? K_LIMIT : cw_bits;
    n = 64'd1 << k;
    q[0] = n - 64'd1;
    for (int i = 0; i < POSITIONS - 1; i++) begin
      d[i] = q[i] % s[i];
      q[i+1] = (q[i] - d[i]) / s[i];
    end
    d[POSITIONS-1] = q[POSITIONS-1] & 64'hFFFF_FFFF;
    q[POSITIONS] = (q[POSITIONS-1] - d[POSITIONS-1]) / s[POSITIONS-1];
    p[0] = 64'd1;
    for (int i = 1; i < POSITIONS; i++) begin
      p[i] = p[i-1] * s[i-1];
    end
    sum = '0;
    for (int i = 0; i < POSITIONS; i++) begin
      for (int j = 0; j < s[i]; j++) begin
        neg = 1'b0;
        if (d[i] > j) begin
          cnt = p[i] * (q[i+1] + 64'd1);
        end else if (d[i] == j) begin
          taken = p[i] * (q[i] - q[i+1]);
          if (taken > n) begin
            cnt = taken - n;
            neg = 1'b1;
          end else begin
            cnt = n - taken;
          end
        end else begin
          cnt = p[i] * q[i+1];
        end
        code = use_codec ? codec_tab[i][j] : plain_tab[i][j];
        lvl = 64'(linear_level(code, mu));
        msq = lvl * lvl;
        term = 128'(msq) * 128'(cnt);
        sum = neg ? sum - term : sum + term;
      end
    end
    idx = LADDER_STEPS - 1;
    if (sum[127]) begin
      r.mean_power = '0;
    end else begin
      shifted = (sum >> k) / 128'd6;
      r.mean_power = (shifted > 128'(MEAN_MAX)) ? MEAN_MAX : MW'(shifted);
      while (idx != 0) begin
        limit = (128'(LADDER[idx]) * 128'd6) << k;
        if (!(limit < sum)) break;
        idx--;
      end
    end
    r.ladder_index = IW'(idx);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      cw_bits <= K_RESET;
      for (int i = 0; i < POSITIONS; i++) pos_size[i] <= SIZE_RESET;
      mismatch_count_o <= 0;
      results_owed_o <= 0;
      power_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (power_due.size() == 0) begin
          if (mismatch_count_o < 10) $display("unexpected output word %p", out_word_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = power_due.pop_front();
          if (want.mean_power !== out_word_i.mean_power ||
              want.ladder_index !== out_word_i.ladder_index) begin
            if (mismatch_count_o < 10) begin
              $display("mismatch: mean_power exp %0d got %0d, ladder_index exp %0d got %0d",
                       want.mean_power, out_word_i.mean_power,
                       want.ladder_index, out_word_i.ladder_index);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.mode) begin
          power_due.push_back(frame_power(in_word_i.use_codec, in_word_i.mu_law));
        end else if (in_word_i.position < POSITIONS) begin
          plain_tab[in_word_i.position][in_word_i.point_number] <= in_word_i.plain_byte;
          codec_tab[in_word_i.position][in_word_i.point_number] <= in_word_i.codec_byte;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegCwBits) begin
          cw_bits <= cfg_wdata_i[5:0];
        end else if (cfg_idx_i >= RegSize0 && cfg_idx_i <= RegSize5) begin
          pos_size[cfg_idx_i - RegSize0] <= cfg_wdata_i;
        end
      end
      results_owed_o <= power_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_pcm_constellation_power_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm constellation power index testbench
// fills both point tables, runs directed and random register settings with
// compute words mixed into table loads, random idling on both channels and
// long output back-pressure; a checker module predicts and compares
// ----------------------------------------------------------------------------
module tb_pcm_constellation_power_index;
  import pcmcpi_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic      clk_i, rst_ni;
  logic      in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_word_t  in_word_i;
  out_word_t out_word_o;
  logic      cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  int        mismatches, results_owed, loads_sent;
  int        cycles = 0;
  int        hold_req;
  logic      idle_on;

  pcm_constellation_power_index DUT (.*);

  pcm_constellation_power_index_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .mismatch_count_o(mismatches), .results_owed_o(results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output side stalls, with one long hold-off on request
  initial begin
    int hold;
    int hold_seen;
    hold = 0;
    hold_seen = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold = 6000;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 15);
      end
    end
  end

  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_load(input logic [2:0] pos, input logic [6:0] pt,
                           input logic [7:0] pb, input logic [7:0] cb);
    in_word_t w;
    w = in_word_t'($urandom);
    w.mode = 1'b0;
    w.position = pos;
    w.point_number = pt;
    w.plain_byte = pb;
    w.codec_byte = cb;
    send_word(w);
    if (pos < POSITIONS) loads_sent++;
  endtask

  task automatic send_compute(input logic use_codec, input logic mu);
    in_word_t w;
    w = in_word_t'($urandom);
    w.mode = 1'b1;
    w.use_codec = use_codec;
    w.mu_law = mu;
    send_word(w);
  endtask

  task automatic send_random_load();
    send_load(($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5)),
              7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait for every result, then let the block drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] k, input logic [7:0] s0, input logic [7:0] s1,
                            input logic [7:0] s2, input logic [7:0] s3,
                            input logic [7:0] s4, input logic [7:0] s5);
    logic [7:0] v [7];
    v = '{k, s0, s1, s2, s3, s4, s5};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= (i == 0) ? RegCwBits : RegSize0 + 3'(i - 1);
      cfg_wdata_i <= v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_size();
    int r;
    r = $urandom_range(19);
    if (r == 0) return ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(129, 255));
    if (r < 3) return 8'd128;
    return 8'($urandom_range(1, 12));
  endfunction

  initial begin
    int phase, n;
    loads_sent = 0;
    hold_req = 0;
    idle_on = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegCwBits;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_regs(8'd42, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    // fill both tables, extreme codes first
    for (int p = 0; p < POSITIONS; p++) begin
      for (int j = 0; j < MAX_POINTS; j++) begin
        case (j)
          0: send_load(3'(p), 7'(j), 8'h00, 8'hFF);
          1: send_load(3'(p), 7'(j), 8'hFF, 8'h00);
          2: send_load(3'(p), 7'(j), 8'h7F, 8'h80);
          3: send_load(3'(p), 7'(j), 8'h80, 8'h7F);
          default: send_load(3'(p), 7'(j), 8'($urandom), 8'($urandom));
        endcase
      end
    end
    send_load(3'd6, 7'd127, 8'hFF, 8'hFF);
    send_load(3'd7, 7'd0, 8'h00, 8'h00);
    for (int c = 0; c < 4; c++) send_compute(c[0], c[1]);
    settle();
    write_regs(8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_compute(1'b0, 1'b1);
    settle();
    write_regs(8'd63, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_compute(1'b1, 1'b0);
    settle();
    write_regs(8'd1, 8'd255, 8'd2, 8'd255, 8'd2, 8'd255, 8'd2);
    send_compute(1'b1, 1'b1);
    settle();
    write_regs(8'd42, 8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13);
    send_compute(1'b0, 1'b0);
    settle();
    write_regs(8'd42, 8'd3, 8'd11, 8'd31, 8'd1, 8'd1, 8'd1);
    send_compute(1'b1, 1'b0);
    settle();

    phase = 0;
    while (loads_sent < 1700) begin
      idle_on = (phase != 0);
      write_regs(8'(($urandom_range(9) == 0) ? $urandom_range(43, 63) : $urandom_range(0, 42)),
                 rand_size(), rand_size(), rand_size(), rand_size(), rand_size(), rand_size());
      if (phase == 3) begin
        hold_req++;
        send_compute(1'($urandom), 1'($urandom));
        repeat (10) send_random_load();
        send_compute(1'($urandom), 1'($urandom));
        repeat (10) send_random_load();
      end
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) send_compute(1'($urandom), 1'($urandom));
        else send_random_load();
      end
      send_compute(1'($urandom), 1'($urandom));
      settle();
      phase++;
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
